@@ sv/ihpq_pkg.sv @@
// Shared constants and types for the indexed binary heap priority queue.
package ihpq_pkg;
   localparam int NodeIds = 64;
   localparam int Capacity = 64;
   localparam int IdBits = 6;
   localparam int SlotBits = 7;
   localparam int PrioBits = 32;
   localparam int ArrBits = 32;

   localparam logic [1:0] FUNC_ENQ = 2'd0;
   localparam logic [1:0] FUNC_DEQ = 2'd1;
   localparam logic [1:0] FUNC_REM = 2'd2;
   localparam logic [1:0] FUNC_NOP = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_NOTQ = 3'd3;
   localparam logic [2:0] ST_ALREADY = 3'd4;

   typedef struct packed {
      logic [PrioBits-1:0] prio;
      logic [ArrBits-1:0] arr;
   } key_type;

   // One word of the per-node memory: the node's key and its heap slot.
   typedef struct packed {
      key_type key;
      logic [SlotBits-1:0] slot;
   } node_word_type;

   // True when key a is served before key b.
   function automatic logic key_before(key_type a, key_type b);
      if (a.prio != b.prio) return a.prio < b.prio;
      return a.arr < b.arr;
   endfunction
endpackage

@@ sv/indexed_binary_heap_priority_queue.sv @@
// Top level: indexed binary min-heap priority queue with removal by node id.
// The response is presented in the cycle after the request transfer for an error
// status or the unused code; an enqueue, dequeue or removal may first move an entry
// through the heap: each level up passes S_PAR0, S_PAR1 and S_UP, each level down S_DN0
// to S_DN4. Requests are handled one at a time; a new request is taken the cycle after
// the response transfer.
// Reset: synchronous, active high; clears the count, arrival counter, the
// per-node queued flags and the control state; the RAMs are not cleared.
module indexed_binary_heap_priority_queue (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // req_tdata: func[1:0], node_id[7:2], priority_req[39:8]
   input  logic [39:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rsp_tdata: status[2:0], out_node_id[8:3], out_priority[40:9], queued_count[47:41]
   output logic [47:0] rsp_tdata
);
   import ihpq_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_DEQ0 = 4'd1, S_DEQ1 = 4'd2,
      S_TAKE0 = 4'd3, S_TAKE1 = 4'd4, S_PAR0 = 4'd5, S_PAR1 = 4'd6,
      S_UP = 4'd7, S_DN0 = 4'd8, S_DN1 = 4'd9, S_DN2 = 4'd10,
      S_DN3 = 4'd11, S_DN4 = 4'd12, S_PLACE = 4'd13, S_RESP = 4'd14,
      S_REM0 = 4'd15;

   logic [3:0] state_ff, state_in;
   // One queued flag per node, so the already-queued and not-queued checks need no
   // memory read and reset clears them at once. The slot itself lives in node memory.
   logic [NodeIds-1:0] queued_ff;
   logic [SlotBits-1:0] count_ff, count_in;
   logic [ArrBits-1:0] arr_ff, arr_in;
   logic [IdBits-1:0] node_ff, node_in, oid_ff, oid_in, best_ff, best_in;
   logic [SlotBits-1:0] pos_ff, pos_in, bpos_ff, bpos_in;
   key_type key_ff, key_in, bkey_ff, bkey_in;
   logic [PrioBits-1:0] oprio_ff, oprio_in;
   logic [2:0] status_ff, status_in;
   logic up_only_ff, up_only_in;

   // Heap slot memory (node per slot) and node memory (key and slot per node).
   logic hs_we; logic [IdBits-1:0] hs_wa, hs_wd, hs_ra, hs_rd;
   logic nm_we; logic [IdBits-1:0] nm_wa, nm_ra; node_word_type nm_wd, nm_rd;
   logic q_we; logic [IdBits-1:0] q_wa; logic q_wd;

   ihpq_ram #(.Depth(NodeIds), .Width(IdBits)) u_slots (.clock, .wr_en(hs_we),
      .wr_addr(hs_wa), .wr_data(hs_wd), .rd_addr(hs_ra), .rd_data(hs_rd));
   ihpq_ram #(.Depth(NodeIds), .Width($bits(node_word_type))) u_nodes (.clock,
      .wr_en(nm_we), .wr_addr(nm_wa), .wr_data(nm_wd), .rd_addr(nm_ra),
      .rd_data(nm_rd));

   logic [1:0] f; logic [IdBits-1:0] rid; logic [PrioBits-1:0] rprio;
   assign f = req_tdata[1:0];
   assign rid = req_tdata[7:2];
   assign rprio = req_tdata[39:8];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata = {count_ff, oprio_ff, oid_ff, status_ff};

   // Slot index is 1-based; RAM address is slot-1.
   function automatic logic [IdBits-1:0] sa(logic [SlotBits-1:0] s);
      logic [SlotBits-1:0] t;
      t = s - 7'd1;
      return t[IdBits-1:0];
   endfunction

   always_comb begin
      state_in = state_ff; count_in = count_ff; arr_in = arr_ff;
      node_in = node_ff; oid_in = oid_ff; best_in = best_ff;
      pos_in = pos_ff; bpos_in = bpos_ff; key_in = key_ff; bkey_in = bkey_ff;
      oprio_in = oprio_ff; status_in = status_ff; up_only_in = up_only_ff;
      hs_we = 1'b0; hs_wa = '0; hs_wd = '0; hs_ra = '0;
      nm_we = 1'b0; nm_wa = '0; nm_wd = '{key: key_ff, slot: pos_ff}; nm_ra = '0;
      q_we = 1'b0; q_wa = '0; q_wd = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            status_in = ST_OK; oid_in = '0; oprio_in = '0; node_in = rid;
            state_in = S_RESP;
            if (f == FUNC_ENQ) begin
               if (queued_ff[rid]) status_in = ST_ALREADY;
               else if (count_ff == SlotBits'(Capacity)) status_in = ST_FULL;
               else begin
                  key_in = '{prio: rprio, arr: arr_ff};
                  q_we = 1'b1; q_wa = rid; q_wd = 1'b1;
                  arr_in = arr_ff + 32'd1;
                  count_in = count_ff + 7'd1;
                  pos_in = count_ff + 7'd1;
                  up_only_in = 1'b1;
                  state_in = S_PAR0;
               end
            end else if (f == FUNC_DEQ) begin
               if (count_ff == '0) status_in = ST_EMPTY;
               else begin hs_ra = '0; state_in = S_DEQ0; end
            end else if (f == FUNC_REM) begin
               if (!queued_ff[rid]) status_in = ST_NOTQ;
               else begin nm_ra = rid; state_in = S_REM0; end
            end
         end
         S_REM0: begin pos_in = nm_rd.slot; state_in = S_TAKE0; end
         S_DEQ0: begin
            node_in = hs_rd; oid_in = hs_rd; nm_ra = hs_rd;
            pos_in = 7'd1; state_in = S_DEQ1;
         end
         S_DEQ1: begin oprio_in = nm_rd.key.prio; state_in = S_TAKE0; end
         S_TAKE0: begin
            // Clear the removed node, fetch the last entry.
            q_we = 1'b1; q_wa = node_ff; q_wd = 1'b0;
            hs_ra = sa(count_ff);
            count_in = count_ff - 7'd1;
            state_in = (pos_ff == count_ff) ? S_RESP : S_TAKE1;
         end
         S_TAKE1: begin
            node_in = hs_rd; nm_ra = hs_rd; up_only_in = 1'b0;
            state_in = S_PAR0;
         end
         S_PAR0: begin
            // key_ff is already valid for an enqueue; a moved entry picks up its key here.
            if (!up_only_ff) key_in = nm_rd.key;
            if (pos_ff > 7'd1) begin
               hs_ra = sa({1'b0, pos_ff[SlotBits-1:1]}); state_in = S_PAR1;
            end else state_in = up_only_ff ? S_PLACE : S_DN0;
         end
         S_PAR1: begin best_in = hs_rd; nm_ra = hs_rd; state_in = S_UP; end
         S_UP: begin
            if (key_before(key_ff, nm_rd.key)) begin
               hs_we = 1'b1; hs_wa = sa(pos_ff); hs_wd = best_ff;
               nm_we = 1'b1; nm_wa = best_ff; nm_wd = '{key: nm_rd.key, slot: pos_ff};
               pos_in = {1'b0, pos_ff[SlotBits-1:1]};
               up_only_in = 1'b1;
               state_in = S_PAR0;
            end else state_in = up_only_ff ? S_PLACE : S_DN0;
         end
         S_DN0: begin
            best_in = node_ff; bkey_in = key_ff; bpos_in = pos_ff;
            if ({pos_ff, 1'b0} > {1'b0, count_ff}) state_in = S_PLACE;
            else begin hs_ra = sa({pos_ff[SlotBits-2:0], 1'b0}); state_in = S_DN1; end
         end
         S_DN1: begin
            // Left child id arrives; fetch its key and the right child id.
            nm_ra = hs_rd; best_in = hs_rd; bpos_in = {pos_ff[SlotBits-2:0], 1'b0};
            if ({pos_ff, 1'b1} <= {1'b0, count_ff})
               hs_ra = sa({pos_ff[SlotBits-2:0], 1'b1});
            state_in = S_DN2;
         end
         S_DN2: begin
            // best_ff holds the left id, nm_rd its key.
            if (key_before(nm_rd.key, key_ff)) bkey_in = nm_rd.key;
            else begin
               best_in = node_ff; bpos_in = pos_ff;
            end
            if ({pos_ff, 1'b1} <= {1'b0, count_ff}) begin
               // Fetch the right key and read the right id again for the next cycle.
               nm_ra = hs_rd;
               hs_ra = sa({pos_ff[SlotBits-2:0], 1'b1});
               state_in = S_DN3;
            end else state_in = S_DN4;
         end
         S_DN3: begin
            if (key_before(nm_rd.key, bkey_ff)) begin
               best_in = hs_rd; bpos_in = {pos_ff[SlotBits-2:0], 1'b1};
               bkey_in = nm_rd.key;
            end
            state_in = S_DN4;
         end
         S_DN4: begin
            if (bpos_ff == pos_ff) state_in = S_PLACE;
            else begin
               hs_we = 1'b1; hs_wa = sa(pos_ff); hs_wd = best_ff;
               nm_we = 1'b1; nm_wa = best_ff; nm_wd = '{key: bkey_ff, slot: pos_ff};
               pos_in = bpos_ff; state_in = S_DN0;
            end
         end
         S_PLACE: begin
            hs_we = 1'b1; hs_wa = sa(pos_ff); hs_wd = node_ff;
            nm_we = 1'b1; nm_wa = node_ff; nm_wd = '{key: key_ff, slot: pos_ff};
            state_in = S_RESP;
         end
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; arr_ff <= '0;
         queued_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; arr_ff <= arr_in;
         if (q_we) queued_ff[q_wa] <= q_wd;
      end
      node_ff <= node_in; oid_ff <= oid_in; best_ff <= best_in;
      pos_ff <= pos_in; bpos_ff <= bpos_in; key_ff <= key_in; bkey_ff <= bkey_in;
      oprio_ff <= oprio_in; status_ff <= status_in; up_only_ff <= up_only_in;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'd64) else $error("count overflow");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while response pending");
endmodule

@@ sv/ihpq_ram.sv @@
// Generic single-port-write, registered-read RAM.
module ihpq_ram #(
   parameter int Depth = 64,
   parameter int Width = 8
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ sim/ihpq_checker.sv @@
// Checker for the indexed binary heap priority queue: predicts and compares every result.
`timescale 1ns / 1ps
module ihpq_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [39:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int fail_count,
   output int pending_count,
   output int queued_now
);
   import ihpq_pkg::*;

   logic [IdBits-1:0] heap_node [1:NodeIds];
   logic [SlotBits-1:0] node_slot [NodeIds];
   logic [PrioBits-1:0] node_prio [NodeIds];
   logic [ArrBits-1:0] node_arr [NodeIds];
   int entries;
   logic [ArrBits-1:0] arrival_next;
   logic [47:0] expected_rsp [$];

   function automatic bit serves_first(int a, int b);
      if (node_prio[a] != node_prio[b]) return node_prio[a] < node_prio[b];
      return node_arr[a] < node_arr[b];
   endfunction

   function automatic void put(int slot, int node);
      heap_node[slot] = IdBits'(node);
      node_slot[node] = SlotBits'(slot);
   endfunction

   function automatic void bubble_up(int node);
      int pos;
      int par;
      pos = int'(node_slot[node]);
      while (pos > 1) begin
         par = int'(heap_node[pos / 2]);
         if (!serves_first(node, par)) break;
         put(pos, par);
         pos = pos / 2;
      end
      put(pos, node);
   endfunction

   function automatic void bubble_down(int node);
      int pos;
      int l;
      int best;
      int bpos;
      pos = int'(node_slot[node]);
      forever begin
         l = 2 * pos;
         best = node;
         bpos = pos;
         if (l > entries) break;
         if (serves_first(int'(heap_node[l]), best)) begin
            best = int'(heap_node[l]);
            bpos = l;
         end
         if (l + 1 <= entries && serves_first(int'(heap_node[l + 1]), best)) begin
            best = int'(heap_node[l + 1]);
            bpos = l + 1;
         end
         if (best == node) break;
         put(pos, best);
         pos = bpos;
      end
      put(pos, node);
   endfunction

   function automatic void unlink(int node);
      int pos;
      int tail;
      pos = int'(node_slot[node]);
      tail = int'(heap_node[entries]);
      node_slot[node] = '0;
      entries--;
      if (pos != entries + 1) begin
         put(pos, tail);
         if (pos > 1 && serves_first(tail, int'(heap_node[pos / 2]))) bubble_up(tail);
         else bubble_down(tail);
      end
   endfunction

   // Applies one request to the shadow heap and returns the packed response.
   function automatic logic [47:0] apply_request(logic [39:0] d);
      logic [1:0] op;
      int id;
      logic [2:0] st;
      logic [IdBits-1:0] oid;
      logic [PrioBits-1:0] oprio;
      op = d[1:0];
      id = int'(d[7:2]);
      st = ST_OK;
      oid = '0;
      oprio = '0;
      if (op == FUNC_ENQ) begin
         if (node_slot[id] != 0) st = ST_ALREADY;
         else if (entries >= Capacity) st = ST_FULL;
         else begin
            node_prio[id] = d[39:8];
            node_arr[id] = arrival_next;
            arrival_next++;
            entries++;
            put(entries, id);
            bubble_up(id);
         end
      end else if (op == FUNC_DEQ) begin
         if (entries == 0) st = ST_EMPTY;
         else begin
            oid = heap_node[1];
            oprio = node_prio[oid];
            unlink(int'(oid));
         end
      end else if (op == FUNC_REM) begin
         if (node_slot[id] == 0) st = ST_NOTQ;
         else unlink(id);
      end
      return {7'(entries), oprio, oid, st};
   endfunction

   assign pending_count = expected_rsp.size();
   assign queued_now = entries;

   always @(posedge clock) begin
      logic [47:0] want;
      if (reset) begin
         for (int i = 0; i < NodeIds; i++) node_slot[i] = '0;
         entries = 0;
         arrival_next = '0;
         fail_count <= 0;
         expected_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response %h with nothing expected", $realtime, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (want[2:0] !== rsp_tdata[2:0] || want[8:3] !== rsp_tdata[8:3]
                   || want[40:9] !== rsp_tdata[40:9]
                   || want[47:41] !== rsp_tdata[47:41]) begin
                  $display("%0t: mismatch expected st=%0d id=%0d prio=%h cnt=%0d",
                     $realtime, want[2:0], want[8:3], want[40:9], want[47:41]);
                  $display("%0t:          actual   st=%0d id=%0d prio=%h cnt=%0d",
                     $realtime, rsp_tdata[2:0], rsp_tdata[8:3], rsp_tdata[40:9],
                     rsp_tdata[47:41]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) expected_rsp.push_back(apply_request(req_tdata));
      end
   end
endmodule

@@ sim/tb_indexed_binary_heap_priority_queue.sv @@
// Testbench top for the indexed binary heap priority queue: stimulus and verdict.
`timescale 1ns / 1ps
module tb_indexed_binary_heap_priority_queue;
   import ihpq_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   int fail_count;
   int pending_count;
   int queued_now;
   int transfers_sent = 0;
   int idle_cycles = 0;
   // The receiver stalls only while this flag is set, so that part of the time
   // responses are taken at once.
   bit stall_rsp = 1'b1;

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   indexed_binary_heap_priority_queue i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   ihpq_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count), .queued_now(queued_now)
   );

   // The receiver stalls on a rotating pattern, with random ready cycles let through,
   // in some stretches and none at all in others.
   always @(negedge clock) begin
      logic [7:0] stall_pattern;
      stall_pattern = 8'b1011_0010;
      if (reset) rsp_tready <= 1'b0;
      else if (!stall_rsp) rsp_tready <= 1'b1;
      else rsp_tready <= stall_pattern[$time % 8] | ($urandom_range(0, 3) == 0);
   end

   // The watchdog ends the run after a long stretch without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offers one request and holds it until the transfer happens. Ready only moves
   // at a rising edge, so its value in the low phase tells whether the next edge
   // takes the request.
   task automatic send_request(logic [1:0] op, logic [5:0] id, logic [31:0] prio);
      logic rdy;
      req_tdata <= {prio, id, op};
      req_tvalid <= 1'b1;
      do begin
         rdy = req_tready;
         @(negedge clock);
      end while (!rdy);
      transfers_sent++;
   endtask

   // Now and then closes a burst with a random gap; most calls add none.
   task automatic maybe_gap();
      int gap;
      if ($urandom_range(0, 5) != 0) return;
      gap = $urandom_range(1, 12);
      req_tvalid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Picks a random id from 0 to span-1, so a narrow span repeats ids often.
   function automatic logic [5:0] pick_id(int span);
      return 6'($urandom_range(0, span - 1));
   endfunction

   initial begin
      logic [1:0] op;
      int span;
      int pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty dequeue, not-queued removal, the unused code, priority
      // extremes, equal priorities decided by arrival, double enqueue.
      send_request(FUNC_DEQ, 6'd0, 32'h0);
      send_request(FUNC_REM, 6'd63, 32'h0);
      send_request(FUNC_NOP, 6'd21, 32'hFFFF_FFFF);
      send_request(FUNC_ENQ, 6'd63, 32'hFFFF_FFFF);
      send_request(FUNC_ENQ, 6'd0, 32'h0);
      send_request(FUNC_ENQ, 6'd5, 32'h8000_0000);
      send_request(FUNC_ENQ, 6'd6, 32'h8000_0000);
      send_request(FUNC_ENQ, 6'd7, 32'h8000_0000);
      send_request(FUNC_ENQ, 6'd63, 32'h1);
      send_request(FUNC_REM, 6'd6, 32'h0);
      send_request(FUNC_NOP, 6'd0, 32'h0);
      repeat (5) send_request(FUNC_DEQ, 6'd0, 32'h0);
      // Fill to capacity, enqueue a queued id once more, then remove every id in a scrambled order.
      for (int i = 0; i < 64; i++) send_request(FUNC_ENQ, 6'(i), $urandom());
      send_request(FUNC_ENQ, 6'd10, 32'h5);
      drain_responses();
      for (int i = 0; i < 64; i++) send_request(FUNC_REM, 6'(i ^ 6'h2a), 32'h0);

      // Random part: stretches of mostly enqueues or mostly dequeues so that the
      // heap grows and shrinks over its full depth, with a narrow id span and
      // few priority values part of the time so ties are common.
      for (int n = 0; n < 660; n++) begin
         if (n % 100 == 0) begin
            span = ($urandom_range(0, 1) != 0) ? 64 : 12;
            stall_rsp = ($urandom_range(0, 3) != 0);
         end
         if (n == 400) drain_responses();
         pick = $urandom_range(0, 99);
         if ((n / 50) % 2 == 0) op = (pick < 65) ? FUNC_ENQ : (pick < 85) ? FUNC_DEQ : FUNC_REM;
         else op = (pick < 25) ? FUNC_ENQ : (pick < 70) ? FUNC_DEQ : FUNC_REM;
         if (pick == 99) op = FUNC_NOP;
         send_request(op, pick_id(span),
            ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 7)) : $urandom());
         maybe_gap();
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("Covered %0d requests: directed corner cases, full and empty heap,",
         transfers_sent);
      $display("removal by id, priority ties and random traffic with stalls (%0d left).",
         queued_now);
      if (fail_count == 0 && pending_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
